// File: sv/htba_pkg.sv
// Shared types and constants for the handle table bump allocator.
// Holds request/result structs, codes, flag bits and the FSM state type.
// No dependencies.
package htba_pkg;

  // Fixed field widths
  localparam int HANDLE_W = 8;
  localparam int SIZE_W   = 16;
  localparam int FLAGS_W  = 16;
  localparam int CAP_W    = 17;

  // Handles reachable through the 8-bit handle field
  localparam int HANDLE_SPAN = 256;

  // Defaults for the top-level parameters
  localparam int DEF_HANDLE_COUNT = 256;
  localparam int DEF_OFFSET_BITS  = 16;

  // Allocated-bit search: bits examined per chunk in the first stage
  localparam int SCAN_CHUNK   = 16;
  localparam int SCAN_CHUNK_W = 4;

  // Heap capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;

  // Entry flag bits
  localparam logic [FLAGS_W-1:0] FLAG_ALLOCATED = 16'h2000;
  localparam logic [FLAGS_W-1:0] FLAG_LOCKED    = 16'h4000;
  localparam logic [FLAGS_W-1:0] FLAG_ZEROINIT  = 16'h0040;

  // Request function codes
  localparam logic [2:0] FN_ALLOC  = 3'd0;
  localparam logic [2:0] FN_LOCK   = 3'd1;
  localparam logic [2:0] FN_UNLOCK = 3'd2;
  localparam logic [2:0] FN_FREE   = 3'd3;
  localparam logic [2:0] FN_SIZE   = 3'd4;
  localparam logic [2:0] FN_FLAGS  = 3'd5;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_HANDLE = 2'd1,
    ST_NO_MEMORY = 2'd2,
    ST_INVALID   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_PICK,
    SEQ_EXEC
  } seq_state_t;

  typedef struct packed {
    logic [2:0]          func;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   request_size;
    logic [FLAGS_W-1:0]  request_flags;
  } in_req_t;

  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle_out;
    logic [15:0]         block_offset;
    logic [SIZE_W-1:0]   size_out;
    logic [FLAGS_W-1:0]  flags_out;
    logic                zero_fill;
  } out_res_t;

  // Update of one allocated bit
  typedef struct packed {
    logic                en;
    logic                set;
    logic [HANDLE_W-1:0] idx;
  } scan_upd_t;

  // Lowest free handle found by the search
  typedef struct packed {
    logic                found;
    logic [HANDLE_W-1:0] idx;
  } scan_res_t;

endpackage

// File: sv/handle_table_bump_allocator_unit.sv
// Handle table bump allocator, top level: sequencer, heap head and result register.
// Depends on htba_pkg, htba_table and htba_scan.
//
// A request passes through the table read, the first search stage, the second
// search stage and execute; busy is high in the scan, pick and execute states,
// and the result strobe out_valid rises for one cycle straight after, in which
// a new request may already be taken. The steps follow the two-stage search
// for the lowest free handle and the registered table read. The receiver cannot
// stall: each result is present for exactly one cycle and must be taken then.
// The allocated bits clear at reset, so the block is ready at once.
module handle_table_bump_allocator_unit #(
  parameter int HANDLE_COUNT = htba_pkg::DEF_HANDLE_COUNT,
  parameter int OFFSET_BITS  = htba_pkg::DEF_OFFSET_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  htba_pkg::in_req_t              in_req,
  output logic                           out_valid,
  output htba_pkg::out_res_t             out_res,
  input  logic                           cfg_we,
  input  logic [htba_pkg::CAP_W-1:0]     cfg_wdata
);
  import htba_pkg::*;

  localparam int DEPTH  = (HANDLE_COUNT < HANDLE_SPAN) ? HANDLE_COUNT : HANDLE_SPAN;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = OFFSET_BITS + SIZE_W + FLAGS_W;
  localparam int CMP_W  = ((OFFSET_BITS > 16) ? OFFSET_BITS : 16) + 2;

  seq_state_t              state_r, state_nxt;
  in_req_t                 req_r;
  logic [CAP_W-1:0]        cap_r;
  logic [OFFSET_BITS-1:0]  head_r, head_nxt;
  out_res_t                res_r, res_nxt;
  logic                    out_valid_r;
  logic                    accept, exec;

  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [WORD_W-1:0]       wr_data, rd_data;
  scan_upd_t               upd;
  scan_res_t               pick;
  logic                    lk_alloc;

  logic [OFFSET_BITS-1:0]  e_off;
  logic [SIZE_W-1:0]       e_size;
  logic [FLAGS_W-1:0]      e_flags, new_flags;
  logic [CMP_W-1:0]        limit, cap_ext, span, sum, off_ext;
  logic                    h_valid;

  assign accept = start && !busy;

  // table memory
  htba_table #(
    .DEPTH (DEPTH),
    .WIDTH (WORD_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (in_req.handle[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // allocated bits and free-handle search
  htba_scan #(
    .DEPTH (DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd),
    .lk_handle (req_r.handle),
    .lk_alloc  (lk_alloc),
    .res       (pick)
  );

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_IDLE: if (start) state_nxt = SEQ_SCAN;
      SEQ_SCAN: state_nxt = SEQ_PICK;
      SEQ_PICK: state_nxt = SEQ_EXEC;
      SEQ_EXEC: state_nxt = SEQ_IDLE;
      default:  state_nxt = SEQ_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    busy = 1'b1;
    exec = 1'b0;
    case (state_r)
      SEQ_IDLE: busy = 1'b0;
      SEQ_EXEC: exec = 1'b1;
      default:  busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_req;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  // unpack the entry read at accept; no write can land between read and use
  assign e_off   = rd_data[WORD_W-1 -: OFFSET_BITS];
  assign e_size  = rd_data[FLAGS_W +: SIZE_W];
  assign e_flags = rd_data[FLAGS_W-1:0];

  // usable limit is the capacity clamped to the offset space
  assign cap_ext = CMP_W'(cap_r);
  assign span    = CMP_W'(1) << OFFSET_BITS;
  assign limit   = (cap_ext > span) ? span : cap_ext;
  assign sum     = CMP_W'(head_r) + CMP_W'(req_r.request_size);
  assign off_ext = CMP_W'(e_off);
  assign h_valid = (32'(req_r.handle) < HANDLE_COUNT) && lk_alloc;

  // execute step
  always_comb begin
    res_nxt   = '0;
    head_nxt  = head_r;
    wr_en     = 1'b0;
    wr_addr   = req_r.handle[IDX_W-1:0];
    wr_data   = rd_data;
    upd       = '0;
    new_flags = e_flags;
    case (req_r.func)
      FN_ALLOC: begin
        new_flags = req_r.request_flags | FLAG_ALLOCATED;
        if (!pick.found) begin
          res_nxt.status = ST_NO_HANDLE;
        end else if (sum >= limit) begin
          res_nxt.status = ST_NO_MEMORY;
        end else begin
          res_nxt.status       = ST_OK;
          res_nxt.handle_out   = pick.idx;
          res_nxt.block_offset = 16'(CMP_W'(head_r));
          res_nxt.size_out     = req_r.request_size;
          res_nxt.flags_out    = new_flags;
          res_nxt.zero_fill    = |(req_r.request_flags & FLAG_ZEROINIT);
          head_nxt             = sum[OFFSET_BITS-1:0];
          wr_en                = exec;
          wr_addr              = pick.idx[IDX_W-1:0];
          wr_data              = {head_r, req_r.request_size, new_flags};
          upd.en               = exec;
          upd.set              = 1'b1;
          upd.idx              = pick.idx;
        end
      end
      FN_LOCK, FN_UNLOCK, FN_FREE, FN_SIZE, FN_FLAGS: begin
        if (!h_valid) begin
          res_nxt.status = ST_INVALID;
        end else begin
          res_nxt.status = ST_OK;
          case (req_r.func)
            FN_LOCK: begin
              new_flags            = e_flags | FLAG_LOCKED;
              res_nxt.block_offset = off_ext[15:0];
              wr_en                = exec;
            end
            FN_UNLOCK: begin
              new_flags = e_flags & ~FLAG_LOCKED;
              wr_en     = exec;
            end
            FN_FREE: begin
              new_flags = e_flags & ~FLAG_ALLOCATED;
              wr_en     = exec;
              upd.en    = exec;
              upd.set   = 1'b0;
              upd.idx   = req_r.handle;
            end
            FN_SIZE:  res_nxt.size_out = e_size;
            default:  new_flags = e_flags;
          endcase
          res_nxt.flags_out = new_flags;
          wr_data           = {e_off, e_size, new_flags};
        end
      end
      default: res_nxt.status = ST_INVALID;
    endcase
  end

  // heap head
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else if (exec) begin
      head_r <= head_nxt;
    end
  end

  // result register and strobe
  always_ff @(posedge clk) begin
    if (exec) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= exec;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: sv/htba_table.sv
// Handle table memory: one write port, one read port, registered read data.
// Each word holds {offset, size, flags}. Depends on nothing.
module htba_table #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 48
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: sv/htba_scan.sv
// Allocated-bit store and two-stage search for the lowest free handle.
// Depends on htba_pkg.
module htba_scan #(
  parameter int DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  htba_pkg::scan_upd_t  upd,
  input  logic [7:0]           lk_handle,
  output logic                 lk_alloc,
  output htba_pkg::scan_res_t  res
);
  import htba_pkg::*;

  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NCHUNK  = (DEPTH + SCAN_CHUNK - 1) / SCAN_CHUNK;
  localparam int PAD     = NCHUNK * SCAN_CHUNK;
  localparam int PIDX_W  = $clog2(PAD);

  logic [DEPTH-1:0]        alloc_r;
  logic [PAD-1:0]          busy_pad;
  logic [NCHUNK-1:0]       chunk_free_nxt, chunk_free_r;
  logic [SCAN_CHUNK_W-1:0] chunk_low_nxt [NCHUNK];
  logic [SCAN_CHUNK_W-1:0] chunk_low_r   [NCHUNK];
  scan_res_t               res_nxt, res_r;

  // allocated bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r <= '0;
    end else if (upd.en) begin
      alloc_r[upd.idx[IDX_W-1:0]] <= upd.set;
    end
  end

  assign lk_alloc = alloc_r[lk_handle[IDX_W-1:0]];

  // pad to whole chunks; padding counts as allocated
  always_comb begin
    busy_pad = '1;
    for (int i = 0; i < DEPTH; i++) begin
      busy_pad[i] = alloc_r[i];
    end
  end

  // stage 1: per chunk, any free bit and the lowest one
  always_comb begin
    for (int c = 0; c < NCHUNK; c++) begin
      chunk_free_nxt[c] = 1'b0;
      chunk_low_nxt[c]  = '0;
      for (int j = SCAN_CHUNK - 1; j >= 0; j--) begin
        if (!busy_pad[c*SCAN_CHUNK + j]) begin
          chunk_free_nxt[c] = 1'b1;
          chunk_low_nxt[c]  = SCAN_CHUNK_W'(j);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    chunk_free_r <= chunk_free_nxt;
    for (int c = 0; c < NCHUNK; c++) begin
      chunk_low_r[c] <= chunk_low_nxt[c];
    end
  end

  // stage 2: lowest chunk with a free bit
  always_comb begin
    logic [PIDX_W-1:0] pick;
    pick          = '0;
    res_nxt.found = 1'b0;
    for (int c = NCHUNK - 1; c >= 0; c--) begin
      if (chunk_free_r[c]) begin
        res_nxt.found = 1'b1;
        pick          = PIDX_W'(c*SCAN_CHUNK + int'(chunk_low_r[c]));
      end
    end
    res_nxt.idx = HANDLE_W'(pick);
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res = res_r;

endmodule
